// ----- rtl/disparity_region_steering_assert.svh -----
// Assertion macros shared by the disparity region steering RTL.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef DISPARITY_REGION_STEERING_ASSERT_SVH
`define DISPARITY_REGION_STEERING_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/drs_pkg.sv -----
// Shared types and constants for the disparity region steering block.
// No dependencies; used by every RTL module of the block.
package drs_pkg;

    localparam int SUM_W    = 36;
    localparam int COUNT_W  = 21;
    localparam int TOTAL_W  = 30;
    localparam int FRAME_W  = 7;
    localparam int DISP_W   = 16;
    localparam int COORD_W  = 10;
    localparam int DVD_W    = SUM_W + 4;
    localparam int DVS_W    = COUNT_W + 1;
    localparam int BITCNT_W = 6;
    localparam int MULT_W   = 22;
    localparam int THR_W    = MULT_W + 4;
    localparam int DRIVE_W  = 8;
    localparam int RULE_W   = 3;
    localparam int REGIONS  = 3;
    localparam int IDX_W    = 2;

    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_TUSER_W  = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 15;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QLVL_W      = 2;

    // floor(x / 3) == (x * RECIP_3) >> RECIP_SHIFT for x below 8192
    localparam logic [15:0] RECIP_3     = 16'd43691;
    localparam int          RECIP_SHIFT = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

    localparam logic [IDX_W-1:0] REG_LEFT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MID   = 2'd1;
    localparam logic [IDX_W-1:0] REG_RIGHT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_THRESH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER   = 3'd4;

    localparam logic [RULE_W-1:0] RULE_CLEAR   = 3'd0;
    localparam logic [RULE_W-1:0] RULE_NEAR    = 3'd1;
    localparam logic [RULE_W-1:0] RULE_BLOCKED = 3'd2;
    localparam logic [RULE_W-1:0] RULE_LEFT    = 3'd3;
    localparam logic [RULE_W-1:0] RULE_RIGHT   = 3'd4;

    localparam logic signed [DRIVE_W-1:0] DRIVE_CLEAR_BASE = 8'sd50;
    localparam logic signed [DRIVE_W-1:0] DRIVE_NEAR_BASE  = 8'sd10;
    localparam logic signed [DRIVE_W-1:0] DRIVE_BOOST      = 8'sd40;
    localparam logic signed [DRIVE_W-1:0] DRIVE_FWD        = 8'sd40;
    localparam logic signed [DRIVE_W-1:0] DRIVE_BLOCK_BACK = -8'sd50;
    localparam logic signed [DRIVE_W-1:0] DRIVE_TURN_BACK  = -8'sd20;

    typedef struct packed {
        logic [10:0]         image_width;
        logic [10:0]         image_height;
        logic [14:0]         near_threshold;
        logic [14:0]         far_threshold;
        logic [FRAME_W-1:0]  frames_per_decision;
    } cfg_t;

    // Per-frame accumulation of one frame, index 0 left, 1 middle, 2 right
    typedef struct packed {
        logic [REGIONS-1:0][SUM_W-1:0]   sum;
        logic [REGIONS-1:0][COUNT_W-1:0] count;
    } frame_stats_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ----- rtl/drs_front.sv -----
// Front end: accepts disparity pixels, sorts them into thirds and sums them.
// Depends on drs_pkg; hands finished frame statistics to drs_fifo.
module drs_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  drs_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [drs_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          q_full,
    output logic                          q_push,
    output drs_pkg::frame_stats_t         q_data
);

    localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
    localparam int HW = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;
    localparam int PW = WW + 17;

    drs_pkg::frame_stats_t stats_reg, stats_next;

    logic signed [drs_pkg::DISP_W-1:0] disparity;
    logic [drs_pkg::COORD_W-1:0]       col, row;
    logic [WW-1:0]                     w, third, two, col_w;
    logic [HW-1:0]                     h, row_h;
    logic [PW-1:0]                     prod_third, prod_two;
    logic                              pix_ok, xfer;
    logic [drs_pkg::REGIONS-1:0]       hit;

    assign disparity = s_tdata[15:0];
    assign col       = s_tdata[25:16];
    assign row       = s_tdata[35:26];

    assign w = (WW'(cfg.image_width) < WW'(MAX_WIDTH)) ? WW'(cfg.image_width) : WW'(MAX_WIDTH);
    assign h = (HW'(cfg.image_height) < HW'(MAX_HEIGHT)) ? HW'(cfg.image_height)
                                                          : HW'(MAX_HEIGHT);

    // Thirds by reciprocal multiply
    assign prod_third = PW'(w) * PW'(drs_pkg::RECIP_3);
    assign prod_two   = PW'({w, 1'b0}) * PW'(drs_pkg::RECIP_3);
    assign third      = WW'(prod_third >> drs_pkg::RECIP_SHIFT);
    assign two        = WW'(prod_two >> drs_pkg::RECIP_SHIFT);

    assign col_w = WW'(col);
    assign row_h = HW'(row);

    assign pix_ok = (disparity > 0) && (row != '0) && (row_h < h) && (col_w < w);

    always_comb begin
        hit = '0;
        if (pix_ok) begin
            if ((col_w >= WW'(1)) && (col_w < third)) begin
                hit[drs_pkg::REG_LEFT] = 1'b1;
            end else if ((col_w >= third) && (col_w < two)) begin
                hit[drs_pkg::REG_MID] = 1'b1;
            end else if (col_w >= two) begin
                hit[drs_pkg::REG_RIGHT] = 1'b1;
            end
        end
    end

    always_comb begin
        stats_next = stats_reg;
        for (int i = 0; i < drs_pkg::REGIONS; i++) begin
            if (hit[i] && (stats_reg.count[i] != drs_pkg::COUNT_MAX)) begin
                stats_next.sum[i]   = stats_reg.sum[i]
                                    + drs_pkg::SUM_W'(unsigned'(disparity[14:0]));
                stats_next.count[i] = stats_reg.count[i] + drs_pkg::COUNT_W'(1);
            end
        end
    end

    assign s_tready = !q_full;
    assign xfer     = s_tvalid && s_tready;
    assign q_push   = xfer && s_tlast;
    assign q_data   = stats_next;

    // Clear the sums once the frame has been handed over
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg <= '0;
        end else if (xfer) begin
            stats_reg <= s_tlast ? '0 : stats_next;
        end
    end

endmodule

// ----- rtl/drs_fifo.sv -----
// Two-entry queue of frame statistics between front and back end.
// Depends on drs_pkg and the shared assertion macros.
`include "disparity_region_steering_assert.svh"

module drs_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  drs_pkg::queue_ctl_t   ctl,
    input  drs_pkg::frame_stats_t push_data,
    output drs_pkg::frame_stats_t pop_data,
    output drs_pkg::queue_stat_t  stat
);

    drs_pkg::frame_stats_t             entry_reg [drs_pkg::QUEUE_DEPTH];
    logic [drs_pkg::QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [drs_pkg::QLVL_W-1:0]        level_reg;

    assign stat.full  = (level_reg == drs_pkg::QLVL_W'(drs_pkg::QUEUE_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (ctl.push) begin
                wr_ptr_reg <= wr_ptr_reg + drs_pkg::QPTR_W'(1);
            end
            if (ctl.pop) begin
                rd_ptr_reg <= rd_ptr_reg + drs_pkg::QPTR_W'(1);
            end
            case ({ctl.push, ctl.pop})
                2'b10:   level_reg <= level_reg + drs_pkg::QLVL_W'(1);
                2'b01:   level_reg <= level_reg - drs_pkg::QLVL_W'(1);
                default: level_reg <= level_reg;
            endcase
        end
    end

    `DRS_ASSERT_IMPL(a_no_push_when_full, ctl.push, !stat.full, "push into full queue")
    `DRS_ASSERT_IMPL(a_no_pop_when_empty, ctl.pop, !stat.empty, "pop from empty queue")

endmodule

// ----- rtl/drs_back.sv -----
// Back end: per-region averages by restoring division, running totals and
// the steering decision with its output register. Depends on drs_pkg.
`include "disparity_region_steering_assert.svh"

module drs_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  drs_pkg::cfg_t                     cfg,
    input  drs_pkg::queue_stat_t              q_stat,
    input  drs_pkg::frame_stats_t             q_data,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [drs_pkg::DRIVE_W-1:0] left_drive,
    output logic signed [drs_pkg::DRIVE_W-1:0] right_drive,
    output logic [drs_pkg::RULE_W-1:0]        rule_taken
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_DIV    = 6'b000100,
        S_ACC    = 6'b001000,
        S_THRESH = 6'b010000,
        S_DECIDE = 6'b100000
    } state_t;

    state_t                                     state_reg, state_next;
    drs_pkg::frame_stats_t                      stats_reg;
    logic [drs_pkg::IDX_W-1:0]                  idx_reg;
    logic [drs_pkg::DVD_W-1:0]                  dvd_reg, quo_reg;
    logic [drs_pkg::DVS_W-1:0]                  dvs_reg, rem_reg, rem_new;
    logic [drs_pkg::DVS_W:0]                    rem_sh, rem_diff;
    logic                                       qbit;
    logic [drs_pkg::BITCNT_W-1:0]               bit_cnt_reg;
    logic [drs_pkg::REGIONS-1:0][drs_pkg::TOTAL_W-1:0] totals_reg;
    logic [drs_pkg::FRAME_W-1:0]                fc_reg, fc_inc;
    logic [drs_pkg::THR_W-1:0]                  tn_reg, tf_reg;
    logic [drs_pkg::MULT_W-1:0]                 near_mul, far_mul;
    logic [drs_pkg::DVD_W:0]                    acc_wide;
    logic [drs_pkg::TOTAL_W-1:0]                acc_sat, tn, tf, lt, mt, rt;
    logic                                       last_region, decision_due, slot_free;
    logic signed [drs_pkg::DRIVE_W-1:0]         ld_dec, rd_dec;
    logic [drs_pkg::RULE_W-1:0]                 rule_dec;
    logic                                       out_valid_reg;
    logic signed [drs_pkg::DRIVE_W-1:0]         ld_reg, rd_reg;
    logic [drs_pkg::RULE_W-1:0]                 rule_reg;

    // One quotient bit per cycle
    assign rem_sh   = {rem_reg, dvd_reg[drs_pkg::DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign qbit     = (rem_sh >= {1'b0, dvs_reg});
    assign rem_new  = qbit ? rem_diff[drs_pkg::DVS_W-1:0] : rem_sh[drs_pkg::DVS_W-1:0];

    // Saturating add of the finished average into the running total
    assign acc_wide = (drs_pkg::DVD_W + 1)'(quo_reg)
                    + (drs_pkg::DVD_W + 1)'(totals_reg[idx_reg]);
    assign acc_sat  = (acc_wide > (drs_pkg::DVD_W + 1)'(drs_pkg::TOTAL_MAX))
                    ? drs_pkg::TOTAL_MAX : drs_pkg::TOTAL_W'(acc_wide);

    assign fc_inc       = (fc_reg < drs_pkg::FRAME_MAX) ? fc_reg + drs_pkg::FRAME_W'(1) : fc_reg;
    assign last_region  = (idx_reg == drs_pkg::REG_RIGHT);
    assign decision_due = (fc_inc >= cfg.frames_per_decision);
    assign slot_free    = !out_valid_reg || m_tready;

    assign near_mul = drs_pkg::MULT_W'(cfg.near_threshold) * drs_pkg::MULT_W'(fc_reg);
    assign far_mul  = drs_pkg::MULT_W'(cfg.far_threshold) * drs_pkg::MULT_W'(fc_reg);

    assign tn = drs_pkg::TOTAL_W'(tn_reg);
    assign tf = drs_pkg::TOTAL_W'(tf_reg);
    assign lt = totals_reg[drs_pkg::REG_LEFT];
    assign mt = totals_reg[drs_pkg::REG_MID];
    assign rt = totals_reg[drs_pkg::REG_RIGHT];

    always_comb begin
        if (mt < tn) begin
            rule_dec = drs_pkg::RULE_CLEAR;
            ld_dec   = drs_pkg::DRIVE_CLEAR_BASE + ((rt < tf) ? drs_pkg::DRIVE_BOOST : '0);
            rd_dec   = drs_pkg::DRIVE_CLEAR_BASE + ((lt < tf) ? drs_pkg::DRIVE_BOOST : '0);
        end else if (mt < tf) begin
            rule_dec = drs_pkg::RULE_NEAR;
            ld_dec   = drs_pkg::DRIVE_NEAR_BASE + ((rt < tn) ? drs_pkg::DRIVE_BOOST : '0);
            rd_dec   = drs_pkg::DRIVE_NEAR_BASE + ((lt < tn) ? drs_pkg::DRIVE_BOOST : '0);
        end else if ((lt > tf) && (rt > tf)) begin
            rule_dec = drs_pkg::RULE_BLOCKED;
            ld_dec   = drs_pkg::DRIVE_FWD;
            rd_dec   = drs_pkg::DRIVE_BLOCK_BACK;
        end else if (lt < rt) begin
            rule_dec = drs_pkg::RULE_LEFT;
            ld_dec   = drs_pkg::DRIVE_TURN_BACK;
            rd_dec   = drs_pkg::DRIVE_FWD;
        end else begin
            rule_dec = drs_pkg::RULE_RIGHT;
            ld_dec   = drs_pkg::DRIVE_FWD;
            rd_dec   = drs_pkg::DRIVE_TURN_BACK;
        end
    end

    assign q_pop = (state_reg == S_IDLE) && !q_stat.empty;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (!q_stat.empty) state_next = S_LOAD;
            S_LOAD:   state_next = S_DIV;
            S_DIV:    if (bit_cnt_reg == drs_pkg::BITCNT_W'(drs_pkg::DVD_W - 1)) begin
                          state_next = S_ACC;
                      end
            S_ACC:    if (!last_region) begin
                          state_next = S_LOAD;
                      end else begin
                          state_next = decision_due ? S_THRESH : S_IDLE;
                      end
            S_THRESH: state_next = S_DECIDE;
            S_DECIDE: if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                stats_reg <= q_data;
            end
            S_LOAD: begin
                dvd_reg     <= {stats_reg.sum[idx_reg], 4'b0000};
                dvs_reg     <= drs_pkg::DVS_W'(stats_reg.count[idx_reg]) + drs_pkg::DVS_W'(1);
                rem_reg     <= '0;
                bit_cnt_reg <= '0;
            end
            S_DIV: begin
                rem_reg     <= rem_new;
                quo_reg     <= {quo_reg[drs_pkg::DVD_W-2:0], qbit};
                dvd_reg     <= {dvd_reg[drs_pkg::DVD_W-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg + drs_pkg::BITCNT_W'(1);
            end
            S_THRESH: begin
                tn_reg <= {near_mul, 4'b0000};
                tf_reg <= {far_mul, 4'b0000};
            end
            S_DECIDE: begin
                if (slot_free) begin
                    ld_reg   <= ld_dec;
                    rd_reg   <= rd_dec;
                    rule_reg <= rule_dec;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= drs_pkg::REG_LEFT;
            totals_reg    <= '0;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Publish a new decision, else drop the valid once it is taken
            if ((state_reg == S_DECIDE) && slot_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    idx_reg <= drs_pkg::REG_LEFT;
                end
                S_ACC: begin
                    totals_reg[idx_reg] <= acc_sat;
                    idx_reg             <= idx_reg + drs_pkg::IDX_W'(1);
                    if (last_region) begin
                        fc_reg <= fc_inc;
                    end
                end
                S_DECIDE: begin
                    if (slot_free) begin
                        totals_reg <= '0;
                        fc_reg     <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign left_drive  = ld_reg;
    assign right_drive = rd_reg;
    assign rule_taken  = rule_reg;

    `DRS_ASSERT_IMPL(a_rem_below_divisor, state_reg == S_DIV, rem_reg < dvs_reg,
                     "division remainder not below divisor")
    `DRS_ASSERT_NEXT(a_decide_waits, (state_reg == S_DECIDE) && out_valid_reg && !m_tready,
                     state_reg == S_DECIDE, "decision overwrote a pending result")
    `DRS_ASSERT_NEXT(a_decide_clears, (state_reg == S_DECIDE) && slot_free,
                     out_valid_reg && (fc_reg == '0) && (totals_reg == '0),
                     "decision did not publish and clear")

endmodule

// ----- rtl/disparity_region_steering.sv -----
// Top level of the disparity region steering block: configuration
// registers, front end, frame queue and back end. Depends on drs_pkg.
//
// Usage:
//   s_* carries one disparity pixel per transaction (Q12.4 disparity, column,
//   row) with s_tlast on the last pixel of a frame. m_* carries one steering
//   decision (left and right drive in percent, rule in m_tuser) after every
//   frames_per_decision frames; other frames produce nothing on m_*.
//   cfg_we/cfg_index/cfg_wdata write the five registers; write them only
//   while the block is idle.
// Throughput: one pixel per cycle while the queue is not full. Each frame
//   end costs the back end a 40-step restoring divider per third, with a
//   load and an accumulate state each, plus a threshold and a decide state
//   when a decision is taken. The queue holds two finished frames, so the
//   front stalls s_tready only when two frame ends wait on the divider.
// Reset: aresetn low clears sums, totals, frame counter, queue and result
//   valid, and loads the register defaults (216 x 162, thresholds 4.0 and
//   8.0, 10 frames). When m_tready is low the result register holds; the
//   back end keeps dividing later frames, but a further decision waits in
//   S_DECIDE, and no frame is popped, until the pending result is taken.
module disparity_region_steering #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [drs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [drs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] disparity, [25:16] col, [35:26] row, [39:36] zero
    input  logic [drs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] left_drive, [15:8] right_drive
    output logic [drs_pkg::OUT_TDATA_W-1:0] m_tdata,
    // [2:0] rule_taken
    output logic [drs_pkg::OUT_TUSER_W-1:0] m_tuser
);

    drs_pkg::cfg_t          cfg_reg;
    drs_pkg::queue_ctl_t    q_ctl;
    drs_pkg::queue_stat_t   q_stat;
    drs_pkg::frame_stats_t  q_wdata, q_rdata;
    logic signed [drs_pkg::DRIVE_W-1:0] left_drive, right_drive;
    logic [drs_pkg::RULE_W-1:0]         rule_taken;
    logic                               q_push, q_pop;

    // Register file; unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width         <= 11'd216;
            cfg_reg.image_height        <= 11'd162;
            cfg_reg.near_threshold      <= 15'd64;
            cfg_reg.far_threshold       <= 15'd128;
            cfg_reg.frames_per_decision <= 7'd10;
        end else if (cfg_we) begin
            case (cfg_index)
                drs_pkg::CFG_IMAGE_WIDTH:  cfg_reg.image_width    <= cfg_wdata[10:0];
                drs_pkg::CFG_IMAGE_HEIGHT: cfg_reg.image_height   <= cfg_wdata[10:0];
                drs_pkg::CFG_NEAR_THRESH:  cfg_reg.near_threshold <= cfg_wdata[14:0];
                drs_pkg::CFG_FAR_THRESH:   cfg_reg.far_threshold  <= cfg_wdata[14:0];
                drs_pkg::CFG_FRAMES_PER:   cfg_reg.frames_per_decision <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Pixel classification and per-frame sums
    drs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_stat.full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    assign q_ctl.push = q_push;
    assign q_ctl.pop  = q_pop;

    // Finished frames wait here for the divider
    drs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (q_ctl),
        .push_data (q_wdata),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    // Averages, totals and the steering decision
    drs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_stat      (q_stat),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .rule_taken  (rule_taken)
    );

    assign m_tdata = {right_drive, left_drive};
    assign m_tuser = rule_taken;

endmodule
